// ----- rtl/core/modbus_slave_data_table_core_macros.svh -----
// assertion helpers for the data table core, sampled on clock, off during reset
`ifndef MODBUS_SLAVE_DATA_TABLE_CORE_MACROS_SVH
`define MODBUS_SLAVE_DATA_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define MDT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MDT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/mdt_pkg.sv -----
`default_nettype none
package mdt_pkg;

   localparam int HOLDING_DEPTH_DEF  = 100;
   localparam int COIL_DEPTH_DEF     = 100;
   localparam int DISCRETE_DEPTH_DEF = 100;
   localparam int ADDRESS_BASE_DEF   = 1;

   // holding register indexes with side effects
   localparam int IDX_WD_RELOAD = 18;
   localparam int IDX_COIL_LO   = 50;
   localparam int IDX_COIL_HI   = 51;
   localparam int IDX_WD_SET    = 52;

   localparam int WD_RESET_VALUE = 1000;
   localparam int BYTE_MASK      = 'hff;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_RD_DISC = 3'd1,
      OP_RD_COIL = 3'd2,
      OP_WR_COIL = 3'd3,
      OP_RD_HOLD = 3'd4,
      OP_WR_HOLD = 3'd5,
      OP_LD_DISC = 3'd6,
      OP_NONE    = 3'd7
   } op_type;

endpackage
`default_nettype wire

// ----- rtl/core/mdt_ram.sv -----
`default_nettype none
module mdt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 100,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      q_ff <= mem[raddr];
   end

   assign rdata = q_ff;

endmodule
`default_nettype wire

// ----- rtl/core/modbus_slave_data_table_core.sv -----
// channel   | ports                                         | handshake
// ----------+-----------------------------------------------+-------------------------------
// request   | req_op req_start req_count req_elem_offset    | beat taken when start && !busy
//           | req_wdata req_last                            |
// response  | rsp_rdata rsp_status rsp_timeout_error        | one beat per request, valid
//           | rsp_coil_word                                 | while rsp_strobe, one cycle
//
// one request at a time: the shortest beats (tick, failed check, unused op, load past
// the table) go from decode straight to the closing state, the longest (coil chunk write)
// runs a read-modify-write through the registered-read holding and bit memories
// after reset a clearing pass over max(holding depth, coil bytes + discrete bytes) addresses
// runs with busy high; the response side cannot stall, each result shows for one cycle
`default_nettype none
`include "modbus_slave_data_table_core_macros.svh"
module modbus_slave_data_table_core
   import mdt_pkg::*;
#(
   parameter int HOLDING_DEPTH  = HOLDING_DEPTH_DEF,
   parameter int COIL_DEPTH     = COIL_DEPTH_DEF,
   parameter int DISCRETE_DEPTH = DISCRETE_DEPTH_DEF,
   parameter int ADDRESS_BASE   = ADDRESS_BASE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [15:0] req_start,
   input  logic [10:0] req_count,
   input  logic [10:0] req_elem_offset,
   input  logic [15:0] req_wdata,
   input  logic        req_last,
   output logic        rsp_strobe,
   output logic [15:0] rsp_rdata,
   output logic        rsp_status,
   output logic        rsp_timeout_error,
   output logic [15:0] rsp_coil_word
);

   // bit memory: coil bytes first, then discrete bytes
   localparam int CB    = (COIL_DEPTH + 7) / 8;
   localparam int DB    = (DISCRETE_DEPTH + 7) / 8;
   localparam int BB    = CB + DB;
   localparam int BAW   = $clog2(BB);
   localparam int HAW   = $clog2(HOLDING_DEPTH);
   localparam int CLR_N = (BB > HOLDING_DEPTH) ? BB : HOLDING_DEPTH;
   localparam int CLW   = $clog2(CLR_N);

   localparam logic [16:0] LIM_HOLD = 17'(ADDRESS_BASE + HOLDING_DEPTH);
   localparam logic [16:0] LIM_COIL = 17'(ADDRESS_BASE + COIL_DEPTH);
   localparam logic [16:0] LIM_DISC = 17'(ADDRESS_BASE + DISCRETE_DEPTH);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE,
      S_BRD0, S_BRD1, S_BRD2, S_BWR0, S_BWR1,
      S_HRD0, S_HRD1, S_HWR, S_HSET,
      S_CCP0, S_CCP1, S_DLD, S_DONE
   } state_type;

   state_type state_ff;
   logic [CLW-1:0] clr_cnt_ff;

   // latched request beat
   op_type      op_ff;
   logic [15:0] start_ff;
   logic [10:0] count_ff;
   logic [10:0] off_ff;
   logic [15:0] wdata_ff;
   logic        last_ff;

   // decoded request
   logic [16:0] pos_ff;
   logic [3:0]  len_ff;
   logic [15:0] mask_ff;
   logic [7:0]  b0_ff;
   logic [15:0] win_ff;
   logic [15:0] rdata_ff;
   logic        status_ff;
   logic        reload_go_ff;

   // watchdog and shadows of memory words the block needs every item
   logic [15:0] wd_ff;
   logic        tmo_ff;
   logic [15:0] reload_ff;
   logic [15:0] coil_lo_ff;

   logic        rsp_strobe_ff;
   logic [15:0] rsp_rdata_ff;
   logic        rsp_status_ff;
   logic        rsp_timeout_error_ff;
   logic [15:0] rsp_coil_word_ff;

   // memory ports
   logic           hwe;
   logic [HAW-1:0] hwaddr;
   logic [15:0]    hwdata;
   logic [HAW-1:0] hraddr;
   logic [15:0]    hq;
   logic           bwe;
   logic [BAW-1:0] bwaddr;
   logic [7:0]     bwdata;
   logic [BAW-1:0] braddr;
   logic [7:0]     bq;

   // decode
   logic [16:0] end_sum;
   logic        base_ok;
   logic        rng_ok;
   logic        is_table;
   logic        off_lt;
   logic [10:0] rem;
   logic [3:0]  len;
   logic [16:0] pos;
   logic        hold_go;

   // chunk datapath
   logic [2:0]  shift;
   logic [15:0] lenmask;
   logic [7:0]  b1;
   logic [15:0] win;
   logic [15:0] rd_chunk;
   logic [15:0] new_win;
   logic [14:0] k_full;
   logic [14:0] k1_full;
   logic [14:0] ccp_addr;

   mdt_ram #(.WIDTH(16), .DEPTH(HOLDING_DEPTH)) u_hold_ram (
      .clock (clock),
      .we    (hwe),
      .waddr (hwaddr),
      .wdata (hwdata),
      .raddr (hraddr),
      .rdata (hq)
   );

   mdt_ram #(.WIDTH(8), .DEPTH(BB)) u_bit_ram (
      .clock (clock),
      .we    (bwe),
      .waddr (bwaddr),
      .wdata (bwdata),
      .raddr (braddr),
      .rdata (bq)
   );

   // range check, chunk length and table position of the latched beat
   always_comb begin
      end_sum = {1'b0, start_ff} + 17'(count_ff);
      base_ok = start_ff >= 16'(ADDRESS_BASE);
      unique case (op_ff)
         OP_RD_DISC: begin
            rng_ok   = base_ok && (end_sum <= LIM_DISC);
            is_table = 1'b1;
         end
         OP_RD_COIL, OP_WR_COIL: begin
            rng_ok   = base_ok && (end_sum <= LIM_COIL);
            is_table = 1'b1;
         end
         OP_RD_HOLD, OP_WR_HOLD: begin
            rng_ok   = base_ok && (end_sum <= LIM_HOLD);
            is_table = 1'b1;
         end
         default: begin
            rng_ok   = 1'b0;
            is_table = 1'b0;
         end
      endcase
      off_lt  = off_ff < count_ff;
      rem     = count_ff - off_ff;
      len     = !off_lt ? 4'd0 : ((rem >= 11'd8) ? 4'd8 : rem[3:0]);
      pos     = 17'(start_ff - 16'(ADDRESS_BASE)) + 17'(off_ff);
      hold_go = rng_ok && off_lt && (pos < 17'(HOLDING_DEPTH));
   end

   // chunk window over two neighboring bytes
   always_comb begin
      shift    = pos_ff[2:0];
      lenmask  = (16'd1 << len_ff) - 16'd1;
      b1       = (mask_ff[15:8] != 8'd0) ? bq : 8'd0;
      win      = {b1, b0_ff};
      rd_chunk = (win >> shift) & lenmask;
      new_win  = (win & ~mask_ff) | ((16'(wdata_ff[7:0]) << shift) & mask_ff);
      k_full   = 15'(pos_ff[16:3]) + ((op_ff == OP_RD_DISC) ? 15'(CB) : 15'd0);
      k1_full  = k_full + 15'd1;
      ccp_addr = (pos_ff == 17'(IDX_COIL_HI)) ? 15'd2 : 15'd0;
   end

   // memory port control
   always_comb begin
      hwe    = 1'b0;
      hwaddr = pos_ff[HAW-1:0];
      hwdata = wdata_ff;
      hraddr = pos_ff[HAW-1:0];
      bwe    = 1'b0;
      bwaddr = BAW'(k_full);
      bwdata = win_ff[7:0];
      braddr = BAW'(k_full);
      unique case (state_ff)
         S_CLEAR: begin
            hwe    = int'(clr_cnt_ff) < HOLDING_DEPTH;
            hwaddr = HAW'(clr_cnt_ff);
            hwdata = (int'(clr_cnt_ff) == IDX_WD_RELOAD) ? 16'(WD_RESET_VALUE) : 16'd0;
            bwe    = int'(clr_cnt_ff) < BB;
            bwaddr = BAW'(clr_cnt_ff);
            bwdata = 8'd0;
         end
         S_BRD1: begin
            braddr = BAW'(k1_full);
         end
         S_BWR0: begin
            bwe = 1'b1;
         end
         S_BWR1: begin
            bwe    = 1'b1;
            bwaddr = BAW'(k1_full);
            bwdata = win_ff[15:8];
         end
         S_HWR: begin
            hwe = 1'b1;
         end
         S_HSET: begin
            hwe    = 1'b1;
            hwaddr = HAW'(IDX_WD_RELOAD);
            hwdata = {6'd0, wdata_ff[7:0], 2'd0};
         end
         S_CCP0: begin
            bwe    = 1'b1;
            bwaddr = BAW'(ccp_addr);
            bwdata = wdata_ff[7:0];
         end
         S_CCP1: begin
            bwe    = 1'b1;
            bwaddr = BAW'(ccp_addr + 15'd1);
            bwdata = wdata_ff[15:8];
         end
         S_DLD: begin
            bwe    = 1'b1;
            bwaddr = BAW'(15'(CB) + 15'(off_ff));
            bwdata = wdata_ff[7:0];
         end
         default: begin
         end
      endcase
   end

   // sequencer with its registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         wd_ff         <= 16'(WD_RESET_VALUE);
         tmo_ff        <= 1'b0;
         reload_ff     <= 16'(WD_RESET_VALUE);
         coil_lo_ff    <= 16'd0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         // strobe for exactly the cycle after the closing state
         rsp_strobe_ff <= (state_ff == S_DONE);

         // keep coil bits 0..15 mirrored for the response
         if (bwe && (bwaddr == BAW'(0))) begin
            coil_lo_ff[7:0] <= bwdata;
         end
         if (bwe && (bwaddr == BAW'(1))) begin
            coil_lo_ff[15:8] <= bwdata;
         end

         unique case (state_ff)
            S_CLEAR: begin
               if (clr_cnt_ff == CLW'(CLR_N - 1)) begin
                  state_ff <= S_IDLE;
               end else begin
                  clr_cnt_ff <= clr_cnt_ff + CLW'(1);
               end
            end
            S_IDLE: begin
               if (start) begin
                  op_ff    <= op_type'(req_op);
                  start_ff <= req_start;
                  count_ff <= req_count;
                  off_ff   <= req_elem_offset;
                  wdata_ff <= req_wdata;
                  last_ff  <= req_last;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               pos_ff       <= pos;
               len_ff       <= len;
               rdata_ff     <= 16'd0;
               status_ff    <= is_table && !rng_ok;
               reload_go_ff <= is_table && rng_ok && last_ff;
               unique case (op_ff)
                  OP_TICK: begin
                     if (reload_ff != 16'd0) begin
                        if (wd_ff != 16'd0) begin
                           wd_ff <= wd_ff - 16'd1;
                        end else begin
                           tmo_ff <= 1'b1;
                        end
                     end else begin
                        tmo_ff <= 1'b0;
                     end
                     state_ff <= S_DONE;
                  end
                  OP_RD_DISC, OP_RD_COIL, OP_WR_COIL: begin
                     state_ff <= (rng_ok && (len != 4'd0)) ? S_BRD0 : S_DONE;
                  end
                  OP_RD_HOLD: begin
                     state_ff <= hold_go ? S_HRD0 : S_DONE;
                  end
                  OP_WR_HOLD: begin
                     state_ff <= hold_go ? S_HWR : S_DONE;
                  end
                  OP_LD_DISC: begin
                     state_ff <= (off_ff < 11'(DB)) ? S_DLD : S_DONE;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_BRD0: begin
               mask_ff  <= lenmask << shift;
               state_ff <= S_BRD1;
            end
            S_BRD1: begin
               b0_ff    <= bq;
               state_ff <= S_BRD2;
            end
            S_BRD2: begin
               if (op_ff == OP_WR_COIL) begin
                  win_ff   <= new_win;
                  state_ff <= S_BWR0;
               end else begin
                  rdata_ff <= rd_chunk;
                  state_ff <= S_DONE;
               end
            end
            S_BWR0: begin
               state_ff <= (mask_ff[15:8] != 8'd0) ? S_BWR1 : S_DONE;
            end
            S_BWR1: begin
               state_ff <= S_DONE;
            end
            S_HRD0: begin
               state_ff <= S_HRD1;
            end
            S_HRD1: begin
               rdata_ff <= hq;
               state_ff <= S_DONE;
            end
            S_HWR: begin
               if (pos_ff == 17'(IDX_WD_RELOAD)) begin
                  reload_ff <= wdata_ff;
               end
               priority if (pos_ff == 17'(IDX_COIL_LO) || pos_ff == 17'(IDX_COIL_HI)) begin
                  state_ff <= S_CCP0;
               end else if (pos_ff == 17'(IDX_WD_SET) && wdata_ff[15:8] == 8'd1) begin
                  state_ff <= S_HSET;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_HSET: begin
               reload_ff <= {6'd0, wdata_ff[7:0] & 8'(BYTE_MASK), 2'd0};
               state_ff  <= S_DONE;
            end
            S_CCP0: begin
               state_ff <= S_CCP1;
            end
            S_CCP1: begin
               state_ff <= S_DONE;
            end
            S_DLD: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               // reload sees register 18 after any side effect of this beat
               if (reload_go_ff) begin
                  wd_ff <= reload_ff;
               end
               rsp_rdata_ff         <= rdata_ff;
               rsp_status_ff        <= status_ff;
               rsp_timeout_error_ff <= tmo_ff;
               rsp_coil_word_ff     <= coil_lo_ff;
               state_ff             <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy              = state_ff != S_IDLE;
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_rdata         = rsp_rdata_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_timeout_error = rsp_timeout_error_ff;
   assign rsp_coil_word     = rsp_coil_word_ff;

   // every beat passes through idle and decode before its closing state, so strobes never touch
   `MDT_ASSERT_NXT(a_strobe_pulse, rsp_strobe, !rsp_strobe, "back-to-back response strobes")
   // an accepted beat is in flight on the next cycle with no stray response
   `MDT_ASSERT_NXT(a_accept_busy, start && !busy, busy && !rsp_strobe, "accept did not go busy")
   // memories are only written by the clearing pass or an active beat
   `MDT_ASSERT_IMP(a_idle_quiet, state_ff == S_IDLE, !hwe && !bwe, "memory write while idle")
   // timeout only latches on a tick
   `MDT_ASSERT_IMP(a_tmo_tick, $rose(tmo_ff),
      $past(state_ff == S_DECODE && op_ff == OP_TICK), "timeout set outside a tick")

endmodule
`default_nettype wire
